[rtl/meo_pkg.sv]
// Shared types and codes for the midpoint ellipse outline engine.
// Used by meo_ctrl, meo_dp and midpoint_ellipse_outline; no dependencies.
package meo_pkg;

    localparam int MAX_SCREEN_DIM = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN    = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // draw modes, also used as the kind of an emitted beat
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_VLINE = 3'd1;
    localparam logic [2:0] MODE_HLINE = 3'd2;
    localparam logic [2:0] MODE_REG1  = 3'd3;
    localparam logic [2:0] MODE_REG2  = 3'd4;

    // multiplier operand pairs
    localparam logic [2:0] MUL_RXRX   = 3'd0;
    localparam logic [2:0] MUL_RYRY   = 3'd1;
    localparam logic [2:0] MUL_RX2RY  = 3'd2;
    localparam logic [2:0] MUL_TT     = 3'd3;
    localparam logic [2:0] MUL_RY2P   = 3'd4;
    localparam logic [2:0] MUL_RR     = 3'd5;
    localparam logic [2:0] MUL_RX2P   = 3'd6;
    localparam logic [2:0] MUL_RX2RY2 = 3'd7;

    // what to do with the registered product
    localparam logic [2:0] ACC_NONE = 3'd0;
    localparam logic [2:0] ACC_RX2  = 3'd1;
    localparam logic [2:0] ACC_RY2  = 3'd2;
    localparam logic [2:0] ACC_INIT = 3'd3;
    localparam logic [2:0] ACC_DQ   = 3'd4;
    localparam logic [2:0] ACC_DADD = 3'd5;
    localparam logic [2:0] ACC_DSUB = 3'd6;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] radius_x;
        logic signed [15:0] radius_y;
    } t_in_beat;

    typedef struct packed {
        logic [19:0] pixel_index;
        logic [7:0]  colour;
        logic        write_enable;
        logic        run_last;
        logic        drawing_done;
    } t_out_beat;

    typedef struct packed {
        logic       load_start;
        logic       line_step;
        logic       ell_step;
        logic       region2;
        logic [2:0] mul_sel;
        logic [2:0] acc_sel;
        logic       emit;
        logic [2:0] emit_kind;
        logic [1:0] emit_pt;
        logic       emit_last;
        logic       emit_done;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] start_mode;
        logic       line_done;
        logic       ell_switch;
        logic       ell_done;
        logic       out_free;
    } t_dp_sts;

endpackage

[rtl/meo_dp.sv]
// Datapath: config registers, ellipse state, shared multiplier, point
// generation and output register. Depends on meo_pkg.
module meo_dp #(
    parameter int P_MAX_DIM = meo_pkg::MAX_SCREEN_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [meo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [meo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  meo_pkg::t_in_beat                i_in_data,
    input  meo_pkg::t_dp_cmd                 i_cmd,
    output meo_pkg::t_dp_sts                 o_sts,
    output logic                             o_out_valid,
    output meo_pkg::t_out_beat               o_out_data,
    input  logic                             i_out_stall
);

    localparam int DIM_W = $clog2(P_MAX_DIM + 1);

    logic [meo_pkg::CFG_DATA_W-1:0] r_scr_w, r_scr_h;
    logic [7:0]                     r_pen;

    logic signed [15:0] r_cc, r_cr, r_rx, r_ry, r_lpos, r_lend;
    logic signed [16:0] r_sc, r_sr, r_px, r_py;
    logic signed [47:0] r_cs, r_rs;
    logic signed [63:0] r_d, r_prod;
    logic signed [31:0] r_rx2, r_ry2;

    logic               r_ov;
    meo_pkg::t_out_beat r_out;

    logic [2:0]         sts_mode;
    logic               sts_line_done, sts_switch, sts_done, sts_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 11'd320;
            r_scr_h <= 11'd240;
            r_pen   <= 8'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == meo_pkg::CFG_WIDTH)  r_scr_w <= i_cfg_data;
            if (i_cfg_idx == meo_pkg::CFG_HEIGHT) r_scr_h <= i_cfg_data;
            if (i_cfg_idx == meo_pkg::CFG_PEN)    r_pen   <= i_cfg_data[7:0];
        end
    end

    // effective screen size, saturated at the maximum
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic signed [16:0] w_s, h_s;
    always_comb begin
        w_eff = (32'(r_scr_w) > 32'(P_MAX_DIM)) ? DIM_W'(P_MAX_DIM) : DIM_W'(r_scr_w);
        h_eff = (32'(r_scr_h) > 32'(P_MAX_DIM)) ? DIM_W'(P_MAX_DIM) : DIM_W'(r_scr_h);
        w_s   = signed'(17'(w_eff));
        h_s   = signed'(17'(h_eff));
    end

    // start classification and line clipping
    logic signed [15:0] cx, cy, rx, ry, la, lb, lo, hi, lo_c, hi_c, lc, lr;
    logic signed [16:0] lim;
    logic               empty;
    always_comb begin
        cx  = i_in_data.center_x;
        cy  = i_in_data.center_y;
        rx  = i_in_data.radius_x;
        ry  = i_in_data.radius_y;
        lc  = (rx == 16'sd0) ? cy : cx;
        lr  = (rx == 16'sd0) ? ry : rx;
        lim = (rx == 16'sd0) ? h_s : w_s;
        la  = lc - lr;
        lb  = lc + lr;
        lo  = (la > lb) ? lb : la;
        hi  = (la > lb) ? la : lb;
        empty = (hi < 16'sd0) || (17'(lo) >= lim);
        lo_c  = (lo < 16'sd0) ? 16'sd0 : lo;
        hi_c  = (17'(hi) >= lim) ? 16'(lim - 17'sd1) : hi;
        if (rx < 16'sd0 || ry < 16'sd0) begin
            sts_mode = meo_pkg::MODE_IDLE;
        end else if (rx == 16'sd0) begin
            sts_mode = (cx < 16'sd0 || 17'(cx) >= w_s || empty) ?
                       meo_pkg::MODE_IDLE : meo_pkg::MODE_VLINE;
        end else if (ry == 16'sd0) begin
            sts_mode = (cy < 16'sd0 || 17'(cy) >= h_s || empty) ?
                       meo_pkg::MODE_IDLE : meo_pkg::MODE_HLINE;
        end else begin
            sts_mode = meo_pkg::MODE_REG1;
        end
    end

    // one midpoint iteration
    logic signed [16:0] sc1, sr1, n_sc, n_sr;
    logic signed [47:0] cs1, rs1, n_cs, n_rs;
    logic signed [63:0] n_d;
    logic               sw;
    always_comb begin
        sc1 = r_sc + 17'sd1;
        sr1 = r_sr - 17'sd1;
        cs1 = r_cs + (48'(r_ry2) <<< 1);
        rs1 = r_rs - (48'(r_rx2) <<< 1);
        sw  = 1'b0;
        if (!i_cmd.region2) begin
            n_sc = sc1;
            n_cs = cs1;
            if (r_d < 64'sd0) begin
                n_sr = r_sr;
                n_rs = r_rs;
                n_d  = r_d + 64'(cs1) + 64'(r_ry2);
            end else begin
                n_sr = sr1;
                n_rs = rs1;
                n_d  = r_d + 64'(cs1) - 64'(rs1) + 64'(r_ry2);
            end
            sw = !(n_cs < n_rs);
        end else begin
            n_sr = sr1;
            n_rs = rs1;
            if (r_d > 64'sd0) begin
                n_sc = r_sc;
                n_cs = r_cs;
                n_d  = r_d + 64'(r_rx2) - 64'(rs1);
            end else begin
                n_sc = sc1;
                n_cs = cs1;
                n_d  = r_d + 64'(cs1) - 64'(rs1) + 64'(r_rx2);
            end
        end
        sts_switch    = sw;
        sts_done      = (i_cmd.region2 || sw) && (n_sr < 17'sd0);
        sts_line_done = (r_lpos >= r_lend);
    end

    // shared multiplier, product registered
    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] w_mul;
    always_comb begin
        unique case (i_cmd.mul_sel)
            meo_pkg::MUL_RXRX:   begin mul_a = 35'(r_rx);  mul_b = 35'(r_rx); end
            meo_pkg::MUL_RYRY:   begin mul_a = 35'(r_ry);  mul_b = 35'(r_ry); end
            meo_pkg::MUL_RX2RY:  begin mul_a = 35'(r_rx2); mul_b = 35'(r_ry); end
            meo_pkg::MUL_TT: begin
                mul_a = (35'(r_sc) <<< 1) + 35'sd1;
                mul_b = (35'(r_sc) <<< 1) + 35'sd1;
            end
            meo_pkg::MUL_RY2P:   begin mul_a = 35'(r_ry2); mul_b = signed'(r_prod[34:0]); end
            meo_pkg::MUL_RR: begin
                mul_a = 35'(r_sr) - 35'sd1;
                mul_b = 35'(r_sr) - 35'sd1;
            end
            meo_pkg::MUL_RX2P:   begin mul_a = 35'(r_rx2); mul_b = signed'(r_prod[34:0]); end
            meo_pkg::MUL_RX2RY2: begin mul_a = 35'(r_rx2); mul_b = 35'(r_ry2); end
            default:             begin mul_a = '0;         mul_b = '0; end
        endcase
        w_mul = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= signed'(w_mul[63:0]);
        if (i_cmd.load_start) begin
            r_cc   <= cx;
            r_cr   <= cy;
            r_rx   <= rx;
            r_ry   <= ry;
            r_lpos <= lo_c;
            r_lend <= hi_c;
        end
        if (i_cmd.line_step) begin
            r_px <= 17'(r_lpos);
            if (!sts_line_done) r_lpos <= r_lpos + 16'sd1;
        end
        if (i_cmd.ell_step) begin
            r_px <= r_sc;
            r_py <= r_sr;
            r_sc <= n_sc;
            r_sr <= n_sr;
            r_cs <= n_cs;
            r_rs <= n_rs;
            r_d  <= n_d;
        end
        unique case (i_cmd.acc_sel)
            meo_pkg::ACC_RX2: r_rx2 <= signed'(r_prod[31:0]);
            meo_pkg::ACC_RY2: r_ry2 <= signed'(r_prod[31:0]);
            meo_pkg::ACC_INIT: begin
                r_sc <= '0;
                r_sr <= 17'(r_ry);
                r_cs <= '0;
                r_rs <= 48'(r_prod <<< 1);
                r_d  <= 64'(r_ry2) - r_prod + 64'(r_rx2 >>> 2);
            end
            meo_pkg::ACC_DQ:   r_d <= r_prod >>> 2;
            meo_pkg::ACC_DADD: r_d <= r_d + r_prod;
            meo_pkg::ACC_DSUB: r_d <= r_d - r_prod;
            default: ;
        endcase
    end

    // point of the current beat
    logic signed [15:0] px, py;
    logic               on;
    logic [31:0]        idx;
    meo_pkg::t_out_beat beat;
    always_comb begin
        unique case (i_cmd.emit_kind)
            meo_pkg::MODE_VLINE: begin px = r_cc;        py = r_px[15:0]; end
            meo_pkg::MODE_HLINE: begin px = r_px[15:0];  py = r_cr; end
            meo_pkg::MODE_REG1, meo_pkg::MODE_REG2: begin
                px = i_cmd.emit_pt[0] ? r_cc - r_px[15:0] : r_cc + r_px[15:0];
                py = i_cmd.emit_pt[1] ? r_cr - r_py[15:0] : r_cr + r_py[15:0];
            end
            default: begin px = 16'sd0; py = 16'sd0; end
        endcase
        on = (i_cmd.emit_kind != meo_pkg::MODE_IDLE) && (px >= 16'sd0) && (py >= 16'sd0)
             && (17'(px) < w_s) && (17'(py) < h_s);
        idx = 32'(unsigned'(px)) * 32'(h_eff) + 32'(unsigned'(py));
        beat.pixel_index  = on ? idx[19:0] : 20'd0;
        beat.colour       = on ? r_pen : 8'd0;
        beat.write_enable = on;
        beat.run_last     = i_cmd.emit_last;
        beat.drawing_done = i_cmd.emit_done;
    end

    assign sts_free = !r_ov || !i_out_stall;

    assign o_sts = '{start_mode: sts_mode, line_done: sts_line_done, ell_switch: sts_switch,
                     ell_done: sts_done, out_free: sts_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit && sts_free) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.emit && sts_free) r_out <= beat;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

[rtl/meo_ctrl.sv]
// Controller: draw mode, request sequencing, multiply schedule and beat count.
// Depends on meo_pkg; drives meo_dp through t_dp_cmd.
module meo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_stall,
    input  meo_pkg::t_dp_sts  i_sts,
    output meo_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT0 = 4'd1;
    localparam logic [3:0] S_INIT1 = 4'd2;
    localparam logic [3:0] S_INIT2 = 4'd3;
    localparam logic [3:0] S_INIT3 = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_SW0   = 4'd6;
    localparam logic [3:0] S_SW1   = 4'd7;
    localparam logic [3:0] S_SW2   = 4'd8;
    localparam logic [3:0] S_SW3   = 4'd9;
    localparam logic [3:0] S_SW4   = 4'd10;
    localparam logic [3:0] S_SW5   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [2:0] r_mode, n_mode, r_kind, n_kind;
    logic [1:0] r_cnt, n_cnt;
    logic       r_tdone, n_tdone, r_sw, n_sw;
    logic       accept, ell;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign ell        = (r_kind == meo_pkg::MODE_REG1);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_tdone = r_tdone;
        n_sw    = r_sw;
        o_cmd            = '0;
        o_cmd.mul_sel    = meo_pkg::MUL_RXRX;
        o_cmd.acc_sel    = meo_pkg::ACC_NONE;
        o_cmd.region2    = (r_mode == meo_pkg::MODE_REG2);
        o_cmd.emit_kind  = r_kind;
        o_cmd.emit_pt    = r_cnt;
        o_cmd.emit_last  = !ell || (r_cnt == 2'd3);
        o_cmd.emit_done  = r_tdone;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == meo_pkg::REQ_START) begin
                    o_cmd.load_start = 1'b1;
                    n_mode = i_sts.start_mode;
                    if (i_sts.start_mode == meo_pkg::MODE_REG1) n_state = S_INIT0;
                end else if (accept) begin
                    n_cnt   = 2'd0;
                    n_sw    = 1'b0;
                    n_state = S_EMIT;
                    unique case (r_mode)
                        meo_pkg::MODE_VLINE, meo_pkg::MODE_HLINE: begin
                            o_cmd.line_step = 1'b1;
                            n_kind  = r_mode;
                            n_tdone = i_sts.line_done;
                            if (i_sts.line_done) n_mode = meo_pkg::MODE_IDLE;
                        end
                        meo_pkg::MODE_REG1, meo_pkg::MODE_REG2: begin
                            o_cmd.ell_step = 1'b1;
                            n_kind  = meo_pkg::MODE_REG1;
                            n_tdone = i_sts.ell_done;
                            n_sw    = i_sts.ell_switch;
                            if (i_sts.ell_done) n_mode = meo_pkg::MODE_IDLE;
                            else if (i_sts.ell_switch) n_mode = meo_pkg::MODE_REG2;
                        end
                        default: begin
                            n_kind  = meo_pkg::MODE_IDLE;
                            n_tdone = 1'b1;
                            n_mode  = meo_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end
            S_INIT0: begin
                o_cmd.mul_sel = meo_pkg::MUL_RXRX;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                o_cmd.mul_sel = meo_pkg::MUL_RYRY;
                o_cmd.acc_sel = meo_pkg::ACC_RX2;
                n_state = S_INIT2;
            end
            S_INIT2: begin
                o_cmd.mul_sel = meo_pkg::MUL_RX2RY;
                o_cmd.acc_sel = meo_pkg::ACC_RY2;
                n_state = S_INIT3;
            end
            S_INIT3: begin
                o_cmd.acc_sel = meo_pkg::ACC_INIT;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) begin
                    if (o_cmd.emit_last) begin
                        n_cnt   = 2'd0;
                        n_state = r_sw ? S_SW0 : S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            // region 2 decision: ry2*(2x+1)^2/4 + rx2*(y-1)^2 - rx2*ry2
            S_SW0: begin
                o_cmd.mul_sel = meo_pkg::MUL_TT;
                n_state = S_SW1;
            end
            S_SW1: begin
                o_cmd.mul_sel = meo_pkg::MUL_RY2P;
                n_state = S_SW2;
            end
            S_SW2: begin
                o_cmd.mul_sel = meo_pkg::MUL_RR;
                o_cmd.acc_sel = meo_pkg::ACC_DQ;
                n_state = S_SW3;
            end
            S_SW3: begin
                o_cmd.mul_sel = meo_pkg::MUL_RX2P;
                n_state = S_SW4;
            end
            S_SW4: begin
                o_cmd.mul_sel = meo_pkg::MUL_RX2RY2;
                o_cmd.acc_sel = meo_pkg::ACC_DADD;
                n_state = S_SW5;
            end
            S_SW5: begin
                o_cmd.acc_sel = meo_pkg::ACC_DSUB;
                n_sw    = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= meo_pkg::MODE_IDLE;
            r_kind  <= meo_pkg::MODE_IDLE;
            r_cnt   <= 2'd0;
            r_tdone <= 1'b0;
            r_sw    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
            r_tdone <= n_tdone;
            r_sw    <= n_sw;
        end
    end

endmodule

[rtl/midpoint_ellipse_outline.sv]
// Top level of the midpoint ellipse outline engine.
// Depends on meo_pkg, meo_ctrl and meo_dp.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+------------------------
//  in      | i_in_valid | o_in_stall  | i_in_data  (t_in_beat)
//  out     | o_out_valid| i_out_stall | o_out_data (t_out_beat)
//  cfg     | i_cfg_we   | -           | i_cfg_idx, i_cfg_data
//
// Start: a true ellipse then squares its radii in states S_INIT0 to S_INIT3.
// Step: a request emits 1 or 4 output beats, each held while the output stalls; the
// tick that enters region 2 then runs the decision multiply sequence (S_SW0 to S_SW5) on the
// single shared multiplier. Results sit in one output register.
// Reset (i_rst_n low, synchronous) idles the engine and restores 320x240, pen 1.
// A stalled output holds the beat; while a tick still has beats to emit the
// engine waits and stalls input, but the last beat may wait while the next
// request is taken.
module midpoint_ellipse_outline #(
    parameter int P_MAX_DIM = meo_pkg::MAX_SCREEN_DIM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [meo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [meo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  meo_pkg::t_in_beat              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output meo_pkg::t_out_beat             o_out_data,
    input  logic                           i_out_stall
);

    meo_pkg::t_dp_cmd cmd;
    meo_pkg::t_dp_sts sts;

    meo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    meo_dp #(
        .P_MAX_DIM (P_MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
